// File: hw/rtl/dsa_pkg.sv
// shared types and constants of the density splat accumulator
package dsa_pkg;

	localparam int POS_W  = 12;   // integer part of a dot coordinate
	localparam int NUM_W  = 41;   // dividend width of the shared divider
	localparam int DEN_W  = 33;   // divisor width of the shared divider
	localparam int LOG_W  = 21;   // log2 result, u5.16
	localparam logic [31:0] DENS_ONE = 32'h0001_0000;

	// register indexes of the configuration port
	localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
	localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_SEL,
		ST_LOAD,
		ST_BMUL,
		ST_BDIV,
		ST_BWAIT,
		ST_WRITE,
		ST_TSEL,
		ST_LOGD,
		ST_LOGP,
		ST_TMUL,
		ST_TDIV,
		ST_TWAIT,
		ST_OUT
	} dsa_state_t;

	typedef enum logic [1:0] {
		TM_LINEAR,
		TM_RATIO,
		TM_LOG
	} tone_mode_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] val;
	} log_req_t;

	typedef struct packed {
		logic             done;
		logic [LOG_W-1:0] res;
	} log_rsp_t;

endpackage

// File: hw/rtl/density_splat_accumulator.sv
// top level: pixel store, update sequencer and tone mapping
// Each dot is split over up to four neighbor pixels; every hit pixel goes through a
// read-modify-write of the pixel store (one entry holds density and color), then a
// tone step, then one result. A dot with no hit pixel goes through accept, setup and
// one check per neighbor. A hit pixel adds load, a blend multiply and divide per
// channel and the write, then the tone: a linear step per channel when the peak is
// at most one, a ratio divide per channel when the peak is above one and the density
// at most one, else two log2 runs and ratio divides (skipped when both logs are
// equal); the result state waits for a free output register. The shared divider gives
// three quotients for the color blend and up to three for the tone, and the iterative
// log2 unit is used twice. After reset the store is cleared one entry per cycle, all
// MAX_WIDTH*MAX_HEIGHT entries, during which no dot is taken; configuration writes
// are taken at any time. A result waiting in the output register does not stop the
// block from working on the next pixel.
module density_splat_accumulator
	import dsa_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// dot_x[19:0], dot_y[39:20], color_red[47:40], color_green[55:48], color_blue[63:56]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_x[8:0], pixel_y[17:9], shade_red[25:18], shade_green[33:26],
	// shade_blue[41:34], zero[47:42]
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int PIX_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = $clog2(PIX_COUNT);
	localparam int XW        = $clog2(MAX_WIDTH);
	localparam int YW        = $clog2(MAX_HEIGHT);

	dsa_state_t state_q, state_d;

	logic [9:0]        act_w_q, act_h_q;
	logic [31:0]       peak_q;
	logic [ADDR_W-1:0] clr_q;
	logic [3:0]        hit_q;
	logic [1:0]        idx_q;
	logic [1:0]        ch_q;
	logic              ovalid_q;

	logic [POS_W-1:0]  x0_q, y0_q;
	logic [7:0]        fx_q, fy_q;
	logic [7:0]        col_q [3];
	logic [7:0]        c0_q [3];
	logic [7:0]        nc_q [3];
	logic [7:0]        shade_q [3];
	logic [11:0]       px_q, py_q;
	logic [16:0]       w_q;
	logic [ADDR_W-1:0] addr_q;
	logic [31:0]       d0_q;
	logic [32:0]       t_q;
	logic [31:0]       dens_q;
	logic [39:0]       prod_a_q;
	logic [24:0]       prod_b_q;
	logic [39:0]       tprod_q;
	logic [31:0]       opnd_q, den_q;
	logic [LOG_W-1:0]  ld_q;
	tone_mode_t        mode_q;
	logic [47:0]       odata_q;
	logic              olast_q;

	logic [55:0]       pix_mem_q [PIX_COUNT];
	logic [55:0]       rdata_q;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [55:0]       mem_wdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	log_req_t          log_req;
	log_rsp_t          log_rsp;

	logic [3:0]        hit_c;
	logic [12:0]       cx, cy;
	logic [8:0]        fa, fb;
	logic [17:0]       w_c;
	logic [ADDR_W-1:0] addr_c;
	logic [31:0]       ds_c;
	logic              out_free;
	logic              last_c;
	logic [40:0]       lin_sum;
	logic [7:0]        lin_shade;
	tone_mode_t        mode_c;

	// neighbor in bounds and with a nonzero weight
	function automatic logic hit_of(input logic [POS_W-1:0] x0, input logic [POS_W-1:0] y0,
			input logic [7:0] fx, input logic [7:0] fy, input logic [1:0] sel,
			input logic [9:0] aw, input logic [9:0] ah);
		logic [12:0] hx, hy;
		logic        wx, wy, inx, iny;
		hx  = {x0[POS_W-1], x0} + {12'b0, sel[1]};
		hy  = {y0[POS_W-1], y0} + {12'b0, sel[0]};
		wx  = sel[1] ? (fx != 8'd0) : 1'b1;
		wy  = sel[0] ? (fy != 8'd0) : 1'b1;
		inx = !hx[12] && ({1'b0, hx[11:0]} < {3'b0, aw})
			&& ({2'b0, hx[11:0]} < 14'(MAX_WIDTH));
		iny = !hy[12] && ({1'b0, hy[11:0]} < {3'b0, ah})
			&& ({2'b0, hy[11:0]} < 14'(MAX_HEIGHT));
		return wx && wy && inx && iny;
	endfunction

	// hit mask of the four neighbors
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hit_c[i] = hit_of(x0_q, y0_q, fx_q, fy_q, 2'(i), act_w_q, act_h_q);
		end
	end

	// coordinates, weight and address of the current neighbor
	assign cx     = {x0_q[POS_W-1], x0_q} + {12'b0, idx_q[1]};
	assign cy     = {y0_q[POS_W-1], y0_q} + {12'b0, idx_q[0]};
	assign fa     = idx_q[1] ? {1'b0, fx_q} : 9'd256 - {1'b0, fx_q};
	assign fb     = idx_q[0] ? {1'b0, fy_q} : 9'd256 - {1'b0, fy_q};
	assign w_c    = fa * fb;
	assign addr_c = ADDR_W'(cy[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx[XW-1:0]);

	assign ds_c      = t_q[32] ? 32'hFFFF_FFFF : t_q[31:0];
	assign out_free  = !ovalid_q || m_axis_tready;
	assign last_c    = (hit_q & (4'b1110 << idx_q)) == 4'b0000;
	assign lin_sum   = 41'(tprod_q) + 41'd32768;
	assign lin_shade = (lin_sum[40:16] > 25'd255) ? 8'hFF : lin_sum[23:16];

	always_comb begin
		if (peak_q <= DENS_ONE) mode_c = TM_LINEAR;
		else if (dens_q <= DENS_ONE) mode_c = TM_RATIO;
		else mode_c = TM_LOG;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == ADDR_W'(PIX_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_SEL;
			ST_SEL: begin
				if (hit_q[idx_q]) state_d = ST_LOAD;
				else if (idx_q == 2'd3) state_d = ST_IDLE;
			end
			ST_LOAD:  state_d = ST_BMUL;
			ST_BMUL:  state_d = ST_BDIV;
			ST_BDIV:  state_d = ST_BWAIT;
			ST_BWAIT: if (div_rsp.done) state_d = (ch_q == 2'd2) ? ST_WRITE : ST_BMUL;
			ST_WRITE: state_d = ST_TSEL;
			ST_TSEL:  state_d = (mode_c == TM_LOG) ? ST_LOGD : ST_TMUL;
			ST_LOGD:  if (log_rsp.done) state_d = ST_LOGP;
			ST_LOGP: begin
				if (log_rsp.done) state_d = (ld_q >= log_rsp.res) ? ST_OUT : ST_TMUL;
			end
			ST_TMUL:  state_d = ST_TDIV;
			ST_TDIV: begin
				if (mode_q != TM_LINEAR) state_d = ST_TWAIT;
				else if (ch_q == 2'd2) state_d = ST_OUT;
				else state_d = ST_TMUL;
			end
			ST_TWAIT: if (div_rsp.done) state_d = (ch_q == 2'd2) ? ST_OUT : ST_TMUL;
			ST_OUT:   if (out_free) state_d = last_c ? ST_IDLE : ST_SEL;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs: memory port, unit requests, handshakes
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_waddr     = addr_q;
		mem_wdata     = {nc_q[2], nc_q[1], nc_q[0], ds_c};
		div_req.start = 1'b0;
		div_req.num   = 41'(prod_a_q) + 41'(prod_b_q) + 41'(t_q[32:1]);
		div_req.den   = t_q;
		log_req.start = 1'b0;
		log_req.val   = dens_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_SEL:   mem_re = hit_q[idx_q];
			ST_BDIV:  div_req.start = 1'b1;
			ST_WRITE: mem_we = 1'b1;
			ST_TSEL:  log_req.start = (mode_c == TM_LOG);
			ST_LOGD: begin
				log_req.start = log_rsp.done;
				log_req.val   = peak_q;
			end
			ST_TDIV: begin
				div_req.start = (mode_q != TM_LINEAR);
				div_req.num   = 41'(tprod_q) + 41'(den_q[31:1]);
				div_req.den   = {1'b0, den_q};
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			act_w_q  <= 10'd512;
			act_h_q  <= 10'd512;
			peak_q   <= '0;
			clr_q    <= '0;
			hit_q    <= '0;
			idx_q    <= '0;
			ch_q     <= '0;
			ovalid_q <= 1'b0;
			mode_q   <= TM_LINEAR;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ACTIVE_WIDTH:  act_w_q <= cfg_data;
					CFG_ACTIVE_HEIGHT: act_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == ST_IDLE) idx_q <= '0;
			if (state_q == ST_SETUP) hit_q <= hit_c;
			if (state_q == ST_SEL && !hit_q[idx_q]) idx_q <= idx_q + 2'd1;
			if (state_q == ST_OUT && out_free) idx_q <= idx_q + 2'd1;
			if (state_q == ST_WRITE && ds_c > peak_q) peak_q <= ds_c;
			if (state_q == ST_TSEL) mode_q <= mode_c;
			// channel counter wraps after blue
			if ((state_q == ST_BWAIT && div_rsp.done) || (state_q == ST_TWAIT && div_rsp.done)
					|| (state_q == ST_TDIV && mode_q == TM_LINEAR)) begin
				ch_q <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
			end
			if (state_q == ST_OUT && out_free) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x0_q     <= s_axis_tdata[19:8];
				fx_q     <= s_axis_tdata[7:0];
				y0_q     <= s_axis_tdata[39:28];
				fy_q     <= s_axis_tdata[27:20];
				col_q[0] <= s_axis_tdata[47:40];
				col_q[1] <= s_axis_tdata[55:48];
				col_q[2] <= s_axis_tdata[63:56];
			end
			ST_SEL: begin
				px_q   <= cx[11:0];
				py_q   <= cy[11:0];
				w_q    <= w_c[16:0];
				addr_q <= addr_c;
			end
			ST_LOAD: begin
				d0_q  <= rdata_q[31:0];
				c0_q[0] <= rdata_q[39:32];
				c0_q[1] <= rdata_q[47:40];
				c0_q[2] <= rdata_q[55:48];
				t_q   <= {1'b0, rdata_q[31:0]} + 33'(w_q);
			end
			ST_BMUL: begin
				prod_a_q <= c0_q[ch_q] * d0_q;
				prod_b_q <= col_q[ch_q] * w_q;
			end
			ST_BWAIT: if (div_rsp.done) nc_q[ch_q] <= div_rsp.quo;
			ST_WRITE: dens_q <= ds_c;
			ST_TSEL: begin
				opnd_q <= dens_q;
				den_q  <= peak_q;
			end
			ST_LOGD: if (log_rsp.done) ld_q <= log_rsp.res;
			ST_LOGP: begin
				if (log_rsp.done) begin
					opnd_q  <= 32'(ld_q);
					den_q   <= 32'(log_rsp.res);
					shade_q <= nc_q;
				end
			end
			ST_TMUL:  tprod_q <= nc_q[ch_q] * opnd_q;
			ST_TDIV:  if (mode_q == TM_LINEAR) shade_q[ch_q] <= lin_shade;
			ST_TWAIT: if (div_rsp.done) shade_q[ch_q] <= div_rsp.quo;
			ST_OUT: begin
				if (out_free) begin
					odata_q <= {6'b0, shade_q[2], shade_q[1], shade_q[0], py_q[8:0], px_q[8:0]};
					olast_q <= last_c;
				end
			end
			default: ;
		endcase
	end

	// pixel store: density in the low word, then red, green, blue
	always_ff @(posedge clk) begin
		if (mem_we) pix_mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= pix_mem_q[addr_c];
	end

	dsa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dsa_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.rsp    (log_rsp)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;

`ifndef ASSERT_OFF
	// a new result is only loaded from the result state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q) == ST_OUT)
		else $error("result loaded outside result state");

	// divider answers only while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_BWAIT || state_q == ST_TWAIT))
		else $error("divider answer not awaited");

	// log unit answers only while the sequencer waits for it
	a_log_wait: assert property (@(posedge clk) disable iff (!arst_n)
		log_rsp.done |-> (state_q == ST_LOGD || state_q == ST_LOGP))
		else $error("log answer not awaited");

	// the peak density never falls
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> peak_q >= $past(peak_q))
		else $error("peak density decreased");
`endif

endmodule

// File: hw/rtl/dsa_divider.sv
// iterative divider, one quotient bit per cycle, quotient saturated to 8 bits
module dsa_divider
	import dsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [2:0]       step_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [7:0]       quo_q;
	logic             ovf;
	logic             fit;

	// quotient of 256 or more saturates at once
	assign ovf = req.num >= {req.den, 8'b0};
	assign fit = rem_q >= dsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				step_q <= 3'd7;
			end else if (busy_q) begin
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 3'd1;
				end
			end
		end
	end

	// restoring steps
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= NUM_W'({req.den, 7'b0});
			quo_q <= ovf ? 8'hFF : 8'h00;
		end else if (busy_q) begin
			if (fit) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[6:0], fit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: hw/rtl/dsa_log2.sv
// iterative log2 of a u16.16 value above one, result u5.16
module dsa_log2
	import dsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  log_req_t req,
	output log_rsp_t rsp
);

	logic        norm_q;
	logic        sq_q;
	logic        done_q;
	logic [3:0]  it_q;
	logic [4:0]  k_q;
	logic [31:0] m_q;
	logic [15:0] fr_q;
	logic [63:0] sq_prod;

	assign sq_prod = m_q * m_q;

	// control: normalize then sixteen squarings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= 1'b0;
			sq_q   <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				norm_q <= 1'b1;
				sq_q   <= 1'b0;
			end else if (norm_q) begin
				if (m_q[31]) begin
					norm_q <= 1'b0;
					sq_q   <= 1'b1;
					it_q   <= 4'd15;
				end
			end else if (sq_q) begin
				if (it_q == 4'd0) begin
					sq_q   <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q - 4'd1;
				end
			end
		end
	end

	// mantissa and fraction bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q  <= req.val;
			k_q  <= 5'd31;
			fr_q <= '0;
		end else if (norm_q) begin
			if (!m_q[31]) begin
				m_q <= m_q << 1;
				k_q <= k_q - 5'd1;
			end
		end else if (sq_q) begin
			if (sq_prod[63]) begin
				m_q  <= sq_prod[63:32];
				fr_q <= {fr_q[14:0], 1'b1};
			end else begin
				m_q  <= sq_prod[62:31];
				fr_q <= {fr_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = {k_q - 5'd16, fr_q};

endmodule

// File: tb/tb_density_splat_accumulator.sv
// testbench of the density splat accumulator: directed and random dots against a predictor
`timescale 1ns / 100ps

module tb_density_splat_accumulator;
	import dsa_pkg::*;

	localparam int GRID_W = 512;
	localparam int GRID_H = 512;
	localparam int SETTLE_CYCLES = 700;

	typedef struct {
		bit [8:0] px;
		bit [8:0] py;
		bit [7:0] red;
		bit [7:0] green;
		bit [7:0] blue;
		bit       last;
	} pixel_update_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [9:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	// predicted image state
	bit [31:0] dens_mem [GRID_W*GRID_H];
	bit [7:0]  red_mem  [GRID_W*GRID_H];
	bit [7:0]  green_mem[GRID_W*GRID_H];
	bit [7:0]  blue_mem [GRID_W*GRID_H];
	bit [31:0] peak_dens;
	int        act_width;
	int        act_height;

	pixel_update_t pending_updates[$];
	int            mismatch_count;
	int            burst_left;
	int            rx_left;
	int            rx_mode;

	density_splat_accumulator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// log2(v) - 16 in u5.16, mantissa squared as u1.31
	function automatic bit [20:0] log_density(bit [31:0] v);
		int        k;
		bit [63:0] m;
		bit [15:0] frac;
		k = 31;
		frac = '0;
		while (k > 0 && !v[k])
			k--;
		if (k < 16)
			return '0;
		m = 64'(v) << (31 - k);
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[i] = 1'b1;
			end
		end
		return {5'(k - 16), frac};
	endfunction

	// tone-mapped channel from new color and density
	function automatic bit [7:0] tone_shade(bit [7:0] c, bit [31:0] d);
		bit [63:0] r;
		bit [20:0] ld;
		bit [20:0] lp;
		if (peak_dens <= DENS_ONE)
			r = (64'(c) * d + 32768) >> 16;
		else if (d <= DENS_ONE)
			r = (64'(c) * d + peak_dens / 2) / peak_dens;
		else begin
			ld = log_density(d);
			lp = log_density(peak_dens);
			if (ld >= lp)
				r = c;
			else
				r = (64'(c) * ld + lp / 2) / lp;
		end
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	// density-weighted color average, rounded
	function automatic bit [7:0] blend_color(bit [7:0] c0, bit [31:0] d0, bit [7:0] c,
			bit [31:0] w, bit [63:0] t);
		bit [63:0] q;
		q = (64'(c0) * d0 + 64'(c) * w + t / 2) / t;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// one neighbor pixel read-modify-write
	function automatic void update_pixel(int x, int y, bit [31:0] w, bit [7:0] cr,
			bit [7:0] cg, bit [7:0] cb);
		int            aw;
		int            ah;
		int            a;
		bit [31:0]     d0;
		bit [63:0]     t;
		bit [31:0]     ds;
		pixel_update_t u;
		aw = (act_width < GRID_W) ? act_width : GRID_W;
		ah = (act_height < GRID_H) ? act_height : GRID_H;
		if (x < 0 || y < 0 || x >= aw || y >= ah || w == 0)
			return;
		a = y * GRID_W + x;
		d0 = dens_mem[a];
		t = 64'(d0) + w;
		red_mem[a] = blend_color(red_mem[a], d0, cr, w, t);
		green_mem[a] = blend_color(green_mem[a], d0, cg, w, t);
		blue_mem[a] = blend_color(blue_mem[a], d0, cb, w, t);
		ds = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
		dens_mem[a] = ds;
		if (ds > peak_dens)
			peak_dens = ds;
		u.px = x[8:0];
		u.py = y[8:0];
		u.red = tone_shade(red_mem[a], ds);
		u.green = tone_shade(green_mem[a], ds);
		u.blue = tone_shade(blue_mem[a], ds);
		u.last = 1'b0;
		pending_updates.push_back(u);
	endfunction

	// split one dot over its four neighbors
	function automatic void splat_dot(bit [63:0] dot);
		int       x0;
		int       y0;
		bit [8:0] fx;
		bit [8:0] fy;
		int       n0;
		x0 = $signed(dot[19:0]) >>> 8;
		y0 = $signed(dot[39:20]) >>> 8;
		fx = {1'b0, dot[7:0]};
		fy = {1'b0, dot[27:20]};
		n0 = pending_updates.size();
		update_pixel(x0, y0, (256 - fx) * (256 - fy), dot[47:40], dot[55:48], dot[63:56]);
		update_pixel(x0, y0 + 1, (256 - fx) * fy, dot[47:40], dot[55:48], dot[63:56]);
		update_pixel(x0 + 1, y0, fx * (256 - fy), dot[47:40], dot[55:48], dot[63:56]);
		update_pixel(x0 + 1, y0 + 1, fx * fy, dot[47:40], dot[55:48], dot[63:56]);
		if (pending_updates.size() > n0)
			pending_updates[pending_updates.size() - 1].last = 1'b1;
	endfunction

	// send one dot, with bursts and gaps
	task automatic send_dot(int x, int y, int r, int g, int b);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {8'(b), 8'(g), 8'(r), 20'(y), 20'(x)};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		splat_dot(s_axis_tdata);
	endtask

	// wait until every expected update has come, then let the block settle
	task automatic drain_updates();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write while idle
	task automatic write_reg(logic idx, int value);
		drain_updates();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= 10'(value);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_ACTIVE_WIDTH)
			act_width = value & 10'h3FF;
		else
			act_height = value & 10'h3FF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_area(int w, int h);
		write_reg(CFG_ACTIVE_WIDTH, w);
		write_reg(CFG_ACTIVE_HEIGHT, h);
	endtask

	// whole and fractional positions, color extremes
	task automatic test_positions();
		send_dot(0, 0, 255, 255, 255);
		send_dot(10 * 256 + 128, 20 * 256 + 128, 0, 0, 0);
		send_dot(40 * 256 + 64, 41 * 256 + 192, 255, 0, 128);
		send_dot(60 * 256 + 1, 61 * 256 + 255, 1, 254, 85);
	endtask

	// neighbors outside the area and the field extremes
	task automatic test_bounds();
		send_dot(511 * 256 + 64, 511 * 256 + 64, 200, 100, 50);
		send_dot(-256 + 128, -256 + 128, 90, 180, 30);
		send_dot(-524288, -524288, 255, 255, 255);
		send_dot(524287, 524287, 255, 255, 255);
		send_dot(-524288, 100 * 256, 10, 20, 30);
		send_dot(-1, -1, 77, 88, 99);
	endtask

	// repeated hits push the peak over one: ratio, log and equal-log tones
	task automatic test_tone_paths();
		send_dot(3 * 256, 3 * 256, 255, 0, 0);
		send_dot(3 * 256, 3 * 256, 0, 255, 0);
		send_dot(3 * 256, 3 * 256, 0, 0, 255);
		send_dot(3 * 256 + 128, 3 * 256, 255, 255, 255);
		send_dot(3 * 256, 3 * 256, 128, 128, 128);
		send_dot(100 * 256 + 32, 100 * 256 + 16, 255, 255, 255);
		send_dot(3 * 256 + 128, 3 * 256, 240, 15, 99);
	endtask

	// single-pixel, empty and clamped active area
	task automatic test_active_size();
		set_area(1, 1);
		send_dot(128, 128, 255, 128, 0);
		set_area(0, 512);
		send_dot(0, 0, 255, 255, 255);
		set_area(1023, 512);
		send_dot(511 * 256 + 128, 10 * 256, 33, 66, 99);
		set_area(512, 0);
		send_dot(5 * 256, 5 * 256, 1, 2, 3);
	endtask

	// random dots, mostly clustered so densities build up
	task automatic random_phase(int count, int span);
		int x;
		int y;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				x = $urandom_range(0, span * 256 - 1);
				y = $urandom_range(0, span * 256 - 1);
			end else if (kind < 8) begin
				x = $urandom_range(0, span - 1) * 256;
				y = $urandom_range(0, span - 1) * 256;
			end else begin
				x = $urandom_range(0, 20'hFFFFF);
				y = $urandom_range(0, 20'hFFFFF);
			end
			if (i == count / 2)
				drain_updates();
			send_dot(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255));
		end
	endtask

	task automatic test_random();
		set_area(512, 512);
		random_phase(110, 6);
		set_area(1023, 7);
		random_phase(110, 8);
		set_area(3, 2);
		random_phase(100, 4);
		set_area(512, 512);
		random_phase(120, 10);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= 1'b0;
		endcase
	end

	// result check
	always @(posedge clk) begin
		pixel_update_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_updates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected update: tdata=%h tlast=%b",
						m_axis_tdata, m_axis_tlast);
			end else begin
				e = pending_updates.pop_front();
				if (m_axis_tdata[8:0] !== e.px || m_axis_tdata[17:9] !== e.py
						|| m_axis_tdata[25:18] !== e.red || m_axis_tdata[33:26] !== e.green
						|| m_axis_tdata[41:34] !== e.blue || m_axis_tlast !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: exp x=%0d y=%0d rgb=%0d,%0d,%0d last=%b",
							e.px, e.py, e.red, e.green, e.blue, e.last);
						$display("          got x=%0d y=%0d rgb=%0d,%0d,%0d last=%b",
							m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tdata[25:18],
							m_axis_tdata[33:26], m_axis_tdata[41:34], m_axis_tlast);
					end
				end
			end
		end
	end

	// time limit
	initial begin
		#60_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ACTIVE_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		mismatch_count = 0;
		burst_left = 0;
		rx_left = 0;
		rx_mode = 0;
		peak_dens = '0;
		act_width = 512;
		act_height = 512;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_positions();
		test_bounds();
		test_tone_paths();
		test_active_size();
		test_random();
		drain_updates();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_divider.sv
hw/rtl/dsa_log2.sv
hw/rtl/density_splat_accumulator.sv
tb/tb_density_splat_accumulator.sv
